### sv/sfir_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and the sequencer state encoding of the symmetric FIR filter.
package sfir_pkg;

	localparam int RING_DEPTH = 64;
	localparam int MAX_TAPS   = 64;
	localparam int COEF_DEPTH = (MAX_TAPS + 1) / 2;
	localparam int TAP_LIMIT  = (MAX_TAPS < RING_DEPTH) ? MAX_TAPS : RING_DEPTH;

	localparam int SAMPLE_W = 16;
	localparam int COEF_W   = 32;
	localparam int CIDX_W   = 5;
	localparam int CFG_W    = 7;
	localparam int ACC_W    = 64;
	localparam int ACC_SHIFT = 16;
	localparam int OUT_W    = 48;
	localparam int PAIR_W   = SAMPLE_W + 1;
	localparam int PROD_W   = COEF_W + PAIR_W;

	localparam int RING_AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int COEF_AW = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
	localparam int TAP_W   = $clog2(TAP_LIMIT + 1);

	localparam logic [CFG_W-1:0] TAP_RESET = CFG_W'(64);

	// Drain wait after the last tap-pair issue until its product sits in the accumulator.
	localparam int PIPE_LAT = 3;
	localparam int LAT_W    = $clog2(PIPE_LAT + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_ISSUE,
		S_DRAIN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic               ring_we;
		logic [RING_AW-1:0] ring_waddr;
		logic               coef_we;
		logic               clr;
		logic               issue;
		logic               mid;
		logic [RING_AW-1:0] addr_a;
		logic [RING_AW-1:0] addr_b;
		logic [COEF_AW-1:0] coef_addr;
		logic               out_load;
	} ctl_t;

endpackage

### sv/sfir_ram.sv
`timescale 1ns / 1ps
// Generic RAM with one write port and two registered read ports.
module sfir_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
	output logic [WIDTH-1:0]                         rdata_a,
	output logic [WIDTH-1:0]                         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

### sv/sfir_mac.sv
`timescale 1ns / 1ps
// Sample ring, coefficient table and the shared pre-add multiply-accumulate datapath.
module sfir_mac (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sfir_pkg::ctl_t                      ctl,
	input  logic signed [sfir_pkg::SAMPLE_W-1:0] sample,
	input  logic [sfir_pkg::CIDX_W-1:0]         coef_index,
	input  logic signed [sfir_pkg::COEF_W-1:0]  coef_value,
	output logic signed [sfir_pkg::OUT_W-1:0]   filtered
);
	import sfir_pkg::*;

	logic [SAMPLE_W-1:0]      rd_a;
	logic [SAMPLE_W-1:0]      rd_b;
	logic [RING_DEPTH-1:0]    vld_q;
	logic [COEF_W-1:0]        coef_q [COEF_DEPTH];

	logic                     en_s1;
	logic                     va_s1;
	logic                     vb_s1;
	logic signed [COEF_W-1:0] coef_s1;

	logic                     en_s2;
	logic signed [PAIR_W-1:0] pair_s2;
	logic signed [COEF_W-1:0] coef_s2;

	logic                     en_s3;
	logic signed [PROD_W-1:0] prod_s3;

	logic [ACC_W-1:0]         acc_q;
	logic [OUT_W-1:0]         filtered_q;

	logic [SAMPLE_W-1:0]      op_a;
	logic [SAMPLE_W-1:0]      op_b;
	logic signed [PAIR_W-1:0] pair_d;

	sfir_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk     (clk),
		.we      (ctl.ring_we),
		.waddr   (ctl.ring_waddr),
		.wdata   (sample),
		.raddr_a (ctl.addr_a),
		.raddr_b (ctl.addr_b),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	// Ring entries that were never written read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ctl.ring_we) begin
			vld_q[ctl.ring_waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < COEF_DEPTH; k++) begin
				coef_q[k] <= '0;
			end
		end else if (ctl.coef_we && (32'(coef_index) < COEF_DEPTH)) begin
			coef_q[coef_index[COEF_AW-1:0]] <= coef_value;
		end
	end

	always_comb begin
		op_a   = va_s1 ? rd_a : '0;
		op_b   = vb_s1 ? rd_b : '0;
		pair_d = $signed({op_a[SAMPLE_W-1], op_a}) + $signed({op_b[SAMPLE_W-1], op_b});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1 <= 1'b0;
			en_s2 <= 1'b0;
			en_s3 <= 1'b0;
		end else begin
			en_s1 <= ctl.issue;
			en_s2 <= en_s1;
			en_s3 <= en_s2;
		end
	end

	always_ff @(posedge clk) begin
		va_s1   <= vld_q[ctl.addr_a];
		vb_s1   <= vld_q[ctl.addr_b] & ~ctl.mid;
		coef_s1 <= coef_q[ctl.coef_addr];
		pair_s2 <= pair_d;
		coef_s2 <= coef_s1;
		prod_s3 <= coef_s2 * pair_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.clr) begin
			acc_q <= '0;
		end else if (en_s3) begin
			acc_q <= acc_q + ACC_W'(prod_s3);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			filtered_q <= acc_q[ACC_SHIFT +: OUT_W];
		end
	end

	assign filtered = filtered_q;

endmodule

### sv/sfir_seq.sv
`timescale 1ns / 1ps
// Sequencer that steps the shared multiply-accumulate unit over the tap pairs.
module sfir_seq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       mode,
	input  logic                       cfg_we,
	input  logic [sfir_pkg::CFG_W-1:0] cfg_wdata,
	output logic                       out_valid,
	input  logic                       out_stall,
	output sfir_pkg::ctl_t             ctl
);
	import sfir_pkg::*;

	localparam int DW = ((RING_AW + 1) > TAP_W) ? (RING_AW + 1) : TAP_W;

	state_t             state_q;
	state_t             state_d;
	logic [CFG_W-1:0]   tap_count_q;
	logic [TAP_W-1:0]   taps_q;
	logic [TAP_W-1:0]   taps_d;
	logic [TAP_W-1:0]   cnt_q;
	logic [TAP_W-1:0]   cnt_d;
	logic [LAT_W-1:0]   lat_q;
	logic [LAT_W-1:0]   lat_d;
	logic [RING_AW-1:0] head_q;
	logic [RING_AW-1:0] wp_q;
	logic               out_valid_q;
	logic               accept;
	logic [TAP_W-1:0]   half;
	logic [TAP_W-1:0]   nsteps;
	logic [TAP_W-1:0]   back_b;

	function automatic logic [RING_AW-1:0] ring_back(input logic [RING_AW-1:0] head,
		input logic [TAP_W-1:0] k);
		logic [DW-1:0] hx;
		logic [DW-1:0] kx;
		logic [DW-1:0] r;
		hx = DW'(head);
		kx = DW'(k);
		if (hx >= kx) begin
			r = hx - kx;
		end else begin
			r = hx + DW'(RING_DEPTH) - kx;
		end
		return r[RING_AW-1:0];
	endfunction

	always_comb begin
		if (tap_count_q == '0) begin
			taps_d = TAP_W'(1);
		end else if (32'(tap_count_q) > TAP_LIMIT) begin
			taps_d = TAP_W'(TAP_LIMIT);
		end else begin
			taps_d = TAP_W'(tap_count_q);
		end
	end

	assign half     = taps_q >> 1;
	assign nsteps   = half + TAP_W'(taps_q[0]);
	assign back_b   = taps_q - TAP_W'(1) - cnt_q;
	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d        = state_q;
		cnt_d          = cnt_q;
		lat_d          = lat_q;
		ctl            = '0;
		ctl.ring_waddr = wp_q;
		ctl.addr_a     = ring_back(head_q, cnt_q);
		ctl.addr_b     = ring_back(head_q, back_b);
		ctl.coef_addr  = cnt_q[COEF_AW-1:0];
		ctl.mid        = taps_q[0] && (cnt_q == half);
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (mode) begin
						ctl.coef_we = 1'b1;
					end else begin
						ctl.ring_we = 1'b1;
						ctl.clr     = 1'b1;
						cnt_d       = '0;
						state_d     = S_ISSUE;
					end
				end
			end
			S_ISSUE: begin
				ctl.issue = 1'b1;
				if (cnt_q == nsteps - TAP_W'(1)) begin
					lat_d   = '0;
					state_d = S_DRAIN;
				end else begin
					cnt_d = cnt_q + TAP_W'(1);
				end
			end
			S_DRAIN: begin
				lat_d = lat_q + LAT_W'(1);
				if (lat_q == LAT_W'(PIPE_LAT - 1)) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					ctl.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tap_count_q <= TAP_RESET;
			taps_q      <= TAP_W'(1);
			cnt_q       <= '0;
			lat_q       <= '0;
			head_q      <= '0;
			wp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			lat_q   <= lat_d;
			if (cfg_we) begin
				tap_count_q <= cfg_wdata;
			end
			if (accept && !mode) begin
				taps_q <= taps_d;
				head_q <= wp_q;
				if (wp_q == RING_AW'(RING_DEPTH - 1)) begin
					wp_q <= '0;
				end else begin
					wp_q <= wp_q + RING_AW'(1);
				end
			end
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_issue_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ISSUE) |-> (cnt_q < nsteps))
		else $error("Tap step counter ran past the last tap pair.");

	a_no_write_during_issue: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.issue |-> (!ctl.ring_we && in_stall))
		else $error("Ring write or input acceptance during a multiply-accumulate step.");

	a_done_loads_word: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |=> (out_valid && state_q == S_IDLE))
		else $error("Finished result word was not presented.");

	a_sample_starts_issue: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !mode) |=> (state_q == S_ISSUE && cnt_q == '0))
		else $error("Accepted sample word did not start the tap sequence.");

endmodule

### sv/symmetric_fir_filter_unit.sv
`timescale 1ns / 1ps
// Input stalls outside the idle state: through a sample's issue, drain and done states.
// The issue state steps ceil(T/2) tap pairs; T = tap_count saturated to 1..64.
// The single pre-add multiply-accumulate unit, one tap pair per cycle, sets the sample rate.
// Coefficient words are taken one per cycle while idle; a stalled result delays the next one.
// Reset: ring reads as zero through per-entry valid bits, coefficients zero, tap_count 64.
// There is no clearing pass; the block takes words from the first cycle after reset.
module symmetric_fir_filter_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 mode,
	input  logic signed [sfir_pkg::SAMPLE_W-1:0] sample,
	input  logic [sfir_pkg::CIDX_W-1:0]          coef_index,
	input  logic signed [sfir_pkg::COEF_W-1:0]   coef_value,
	input  logic                                 cfg_we,
	input  logic [sfir_pkg::CFG_W-1:0]           cfg_wdata,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [sfir_pkg::OUT_W-1:0]    filtered
);
	import sfir_pkg::*;

	ctl_t ctl;

	sfir_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ctl       (ctl)
	);

	sfir_mac u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sample     (sample),
		.coef_index (coef_index),
		.coef_value (coef_value),
		.filtered   (filtered)
	);

endmodule

### test/sfir_tb_pkg.sv
`timescale 1ns / 1ps
// Word kinds shared by the symmetric FIR filter testbench top and its checker.
package sfir_tb_pkg;

	typedef enum logic {
		MODE_SAMPLE = 1'b0,
		MODE_COEF   = 1'b1
	} word_mode_t;

endpackage

### test/sfir_checker.sv
`timescale 1ns / 1ps
// Checker that models the symmetric FIR filter, predicts each filter output and compares it.
module sfir_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic                                 in_stall,
	input  logic                                 mode,
	input  logic signed [sfir_pkg::SAMPLE_W-1:0] sample,
	input  logic [sfir_pkg::CIDX_W-1:0]          coef_index,
	input  logic signed [sfir_pkg::COEF_W-1:0]   coef_value,
	input  logic                                 cfg_we,
	input  logic [sfir_pkg::CFG_W-1:0]           cfg_wdata,
	input  logic                                 out_valid,
	input  logic                                 out_stall,
	input  logic signed [sfir_pkg::OUT_W-1:0]    filtered,
	output int                                   fail_count,
	output int                                   pending_results,
	output int                                   results_checked
);
	import sfir_pkg::*;
	import sfir_tb_pkg::*;

	logic signed [SAMPLE_W-1:0] ring [RING_DEPTH];
	logic [RING_AW-1:0]         newest;
	logic signed [COEF_W-1:0]   coefs [COEF_DEPTH];
	logic [CFG_W-1:0]           tap_count;
	logic signed [OUT_W-1:0]    filtered_q [$];
	logic signed [OUT_W-1:0]    want;
	int                         errors = 0;
	int                         checked = 0;

	function automatic logic signed [ACC_W-1:0] older_sample(int age);
		logic signed [ACC_W-1:0] v;
		v = ring[(int'(newest) + RING_DEPTH - age) % RING_DEPTH];
		return v;
	endfunction

	function automatic logic signed [OUT_W-1:0] filter_output();
		int                      taps;
		int                      half;
		logic signed [ACC_W-1:0] acc;
		logic signed [ACC_W-1:0] c;
		logic signed [ACC_W-1:0] pair;
		taps = tap_count;
		if (taps < 1)
			taps = 1;
		if (taps > TAP_LIMIT)
			taps = TAP_LIMIT;
		half = taps / 2;
		acc = '0;
		for (int i = 0; i < half; i++) begin
			c = coefs[i];
			pair = older_sample(i) + older_sample(taps - 1 - i);
			acc = acc + c * pair;
		end
		if (taps % 2 == 1) begin
			c = coefs[half];
			acc = acc + c * older_sample(half);
		end
		return acc[ACC_W-1:ACC_SHIFT];
	endfunction

	task automatic note_failure(string what, logic signed [OUT_W-1:0] exp_v,
			logic signed [OUT_W-1:0] act_v);
		if (errors < 10)
			$display("%0t: %s: expected %0d, got %0d", $realtime, what, exp_v, act_v);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RING_DEPTH; i++)
				ring[i] = '0;
			for (int i = 0; i < COEF_DEPTH; i++)
				coefs[i] = '0;
			newest = '0;
			tap_count = TAP_RESET;
			filtered_q.delete();
		end else begin
			if (cfg_we)
				tap_count = cfg_wdata;
			if (out_valid && !out_stall) begin
				if (filtered_q.size() == 0) begin
					note_failure("filtered word with nothing outstanding", '0, filtered);
				end else begin
					want = filtered_q.pop_front();
					checked++;
					if (filtered !== want)
						note_failure("filtered mismatch", want, filtered);
				end
			end
			if (in_valid && !in_stall) begin
				if (mode == MODE_COEF) begin
					if (coef_index < COEF_DEPTH)
						coefs[coef_index] = coef_value;
				end else begin
					ring[newest] = sample;
					filtered_q.push_back(filter_output());
					newest = newest + 1'b1;
				end
			end
		end
		fail_count <= errors;
		pending_results <= filtered_q.size();
		results_checked <= checked;
	end

endmodule

### test/tb_symmetric_fir_filter_unit.sv
`timescale 1ns / 1ps
// Testbench top that drives sample and coefficient words into the symmetric FIR filter.
module tb_symmetric_fir_filter_unit;
	import sfir_pkg::*;
	import sfir_tb_pkg::*;

	localparam int WATCHDOG_LIMIT     = 5000;
	localparam int SETTLE_CYCLES      = 48;
	localparam int SEGMENT_ITEMS      = 108;
	localparam int SEGMENTS_PER_PHASE = 6;
	localparam int PLANNED_TAPS       = 10;
	localparam logic [CFG_W-1:0] TAP_PLAN [PLANNED_TAPS] =
		'{7'd0, 7'd1, 7'd2, 7'd3, 7'd127, 7'd64, 7'd63, 7'd33, 7'd32, 7'd65};

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic                       mode = MODE_SAMPLE;
	logic signed [SAMPLE_W-1:0] sample = '0;
	logic [CIDX_W-1:0]          coef_index = '0;
	logic signed [COEF_W-1:0]   coef_value = '0;
	logic                       cfg_we = 1'b0;
	logic [CFG_W-1:0]           cfg_wdata = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic signed [OUT_W-1:0]    filtered;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int samples_sent = 0;
	int coefs_sent = 0;
	int tap_settings = 0;
	int quiet_cycles = 0;
	int fail_count;
	int pending_results;
	int results_checked;

	always #5 clk = ~clk;

	symmetric_fir_filter_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.sample     (sample),
		.coef_index (coef_index),
		.coef_value (coef_value),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.filtered   (filtered)
	);

	sfir_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.mode            (mode),
		.sample          (sample),
		.coef_index      (coef_index),
		.coef_value      (coef_value),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.filtered        (filtered),
		.fail_count      (fail_count),
		.pending_results (pending_results),
		.results_checked (results_checked)
	);

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
			$display("Some tests failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		unique case ($urandom_range(15))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return '0;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic logic signed [COEF_W-1:0] rand_coef();
		unique case ($urandom_range(15))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2: return -32'sd1;
			3, 4, 5: return $signed(COEF_W'($urandom_range(65535))) - 32'sd32768;
			default: return COEF_W'($urandom);
		endcase
	endfunction

	task automatic send_word(word_mode_t kind, logic signed [SAMPLE_W-1:0] smp,
			logic [CIDX_W-1:0] idx, logic signed [COEF_W-1:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= kind;
		sample <= smp;
		coef_index <= idx;
		coef_value <= val;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (kind == MODE_COEF)
			coefs_sent++;
		else
			samples_sent++;
	endtask

	task automatic send_sample(logic signed [SAMPLE_W-1:0] smp);
		send_word(MODE_SAMPLE, smp, CIDX_W'($urandom), COEF_W'($urandom));
	endtask

	task automatic send_coef(logic [CIDX_W-1:0] idx, logic signed [COEF_W-1:0] val);
		send_word(MODE_COEF, SAMPLE_W'($urandom), idx, val);
	endtask

	task automatic wait_for_quiet();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic set_tap_count(logic [CFG_W-1:0] value);
		wait_for_quiet();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		tap_settings++;
	endtask

	task automatic random_word();
		if ($urandom_range(99) < 15)
			send_coef(CIDX_W'($urandom), rand_coef());
		else
			send_sample(rand_sample());
	endtask

	initial begin
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_sample(16'sh7FFF);
		send_coef(5'd0, 32'sh7FFFFFFF);
		send_coef(5'd31, 32'sh80000000);
		send_coef(5'd1, -32'sd1);
		send_coef(5'd16, 32'sh12345678);
		send_sample(16'sh8000);
		send_sample(16'sh7FFF);
		send_sample(16'sd1);
		send_sample(-16'sd1);
		set_tap_count(7'd1);
		send_sample(16'sh8000);
		send_sample(16'sh7FFF);
		set_tap_count(7'd0);
		send_sample(16'sd100);
		set_tap_count(7'd127);
		send_sample(16'sh8000);
		send_coef(5'd31, -32'sd1);
		send_sample(16'sh7FFF);
		set_tap_count(7'd63);
		send_sample(-16'sd5);
		send_sample(16'sh8000);

		for (int phase = 0; phase < 3; phase++) begin
			unique case (phase)
				0: begin
					send_idle_pct = 36;
					recv_idle_pct = 80;
				end
				1: begin
					send_idle_pct = 80;
					recv_idle_pct = 36;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int seg = 0; seg < SEGMENTS_PER_PHASE; seg++) begin
				if (tap_settings - 4 < PLANNED_TAPS)
					set_tap_count(TAP_PLAN[tap_settings - 4]);
				else
					set_tap_count(CFG_W'($urandom_range(127)));
				repeat (SEGMENT_ITEMS)
					random_word();
			end
		end

		wait_for_quiet();
		recv_idle_pct = 0;
		$display("Sent %0d sample words and %0d coefficient words over %0d tap settings.",
			samples_sent, coefs_sent, tap_settings);
		$display("Compared %0d filtered words; %0d failures.", results_checked, fail_count);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

### symmetric_fir_filter_unit.f
sv/sfir_pkg.sv
sv/sfir_ram.sv
sv/sfir_mac.sv
sv/sfir_seq.sv
sv/symmetric_fir_filter_unit.sv
test/sfir_tb_pkg.sv
test/sfir_checker.sv
test/tb_symmetric_fir_filter_unit.sv
